>>> hdl/fscm_pkg.sv
// Shared constants, tables and rounding helper for the flux surface coordinate map.
package fscm_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  // Root unit widths: psi root and the two wide roots.
  localparam int PSI_ROOT_W  = 32;
  localparam int WIDE_ROOT_W = 64;

  // Shared divider geometry (dividend, divisor, quotient bits).
  localparam int DIV_DW = 51;
  localparam int DIV_VW = 33;
  localparam int DIV_QW = 21;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Taylor series divisors and their reciprocals scaled by 2^SIN_RECIP_SH.
  localparam int SIN_ITERS    = 5;
  localparam int SIN_RECIP_SH = 36;
  localparam logic [6:0] SIN_DIV [SIN_ITERS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [33:0] SIN_RECIP [SIN_ITERS] = '{
    34'd624722515, 34'd954437176, 34'd1636178017, 34'd3435973836, 34'd11453246122
  };

  localparam logic [15:0] ASPECT_RST = 16'd19661;
  localparam logic [15:0] ELONG_RST  = 16'd4096;
  localparam logic [15:0] TRIANG_RST = 16'd0;

  typedef enum logic [1:0] {
    REG_ASPECT = 2'd0,
    REG_ELONG  = 2'd1,
    REG_TRIANG = 2'd2
  } reg_idx_t;

  // Signed shift right by n, rounded to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q = (mag + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

>>> hdl/fscm_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a side tag.
module fscm_sqrt #(
  parameter int W     = fscm_pkg::PSI_ROOT_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [W-1:0]     in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [W/2-1:0]   out_root,
  output logic [TAG_W-1:0] out_tag
);
  localparam int K = W / 2;

  logic [W-1:0]     v_q   [K];
  logic [W-1:0]     r_q   [K];
  logic             vld_q [K];
  logic [TAG_W-1:0] tag_q [K];

  for (genvar k = 0; k < K; k++) begin : g_stage
    logic [W-1:0]     v_in, r_in, bitv, sum, v_nx, r_nx;
    logic             vl_in;
    logic [TAG_W-1:0] tg_in;

    if (k == 0) begin : g_src
      assign v_in  = in_val;
      assign r_in  = '0;
      assign vl_in = in_vld;
      assign tg_in = in_tag;
    end else begin : g_chain
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign vl_in = vld_q[k-1];
      assign tg_in = tag_q[k-1];
    end

    assign bitv = W'(1) << (W - 2 - 2 * k);

    always_comb begin
      sum = r_in + bitv;
      if (v_in >= sum) begin
        v_nx = v_in - sum;
        r_nx = (r_in >> 1) + bitv;
      end else begin
        v_nx = v_in;
        r_nx = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[k]   <= v_nx;
        r_q[k]   <= r_nx;
        tag_q[k] <= tg_in;
      end
    end
  end

  assign out_vld  = vld_q[K-1];
  assign out_root = r_q[K-1][W/2-1:0];
  assign out_tag  = tag_q[K-1];

endmodule

>>> hdl/fscm_sine.sv
// Pipelined quarter-turn sine pair (sin of frac and of its complement), Taylor form.
module fscm_sine #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [29:0]      frac,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [16:0]      sin_a,
  output logic [16:0]      sin_b,
  output logic [TAG_W-1:0] out_tag
);
  import fscm_pkg::*;

  typedef struct packed {
    logic [1:0][30:0] x;
    logic [1:0][31:0] x2;
    logic [TAG_W-1:0] tag;
  } carry_t;

  // stage 1: x = r * pi/2
  logic             s1_vld;
  logic [1:0][30:0] s1_x;
  logic [TAG_W-1:0] s1_tag;
  logic [1:0][30:0] r_in;
  logic [1:0][61:0] x_prod;

  assign r_in[0] = {1'b0, frac};
  assign r_in[1] = Q30_ONE - {1'b0, frac};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      x_prod[l] = 62'(r_in[l]) * 62'(HALF_PI_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        s1_x[l] <= x_prod[l][60:30];
      end
      s1_tag <= in_tag;
    end
  end

  // stage 2: x^2
  logic             s2_vld;
  carry_t           s2_c;
  logic [1:0][61:0] sq_prod;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq_prod[l] = 62'(s1_x[l]) * 62'(s1_x[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c.x   <= s1_x;
      s2_c.tag <= s1_tag;
      for (int l = 0; l < 2; l++) begin
        s2_c.x2[l] <= sq_prod[l][61:30];
      end
    end
  end

  // Horner steps: t = 1 - ((x2 * t) >> 30) / div, three stages each
  carry_t           a_c  [SIN_ITERS];
  logic             a_v  [SIN_ITERS];
  logic [1:0][31:0] a_y  [SIN_ITERS];
  carry_t           b_c  [SIN_ITERS];
  logic             b_v  [SIN_ITERS];
  logic [1:0][31:0] b_y  [SIN_ITERS];
  logic [1:0][31:0] b_q  [SIN_ITERS];
  carry_t           it_c [SIN_ITERS];
  logic             it_v [SIN_ITERS];
  logic [1:0][30:0] it_t [SIN_ITERS];

  for (genvar i = 0; i < SIN_ITERS; i++) begin : g_iter
    carry_t           c_in;
    logic             v_in;
    logic [1:0][30:0] t_in;
    logic [1:0][62:0] yp;
    logic [1:0][67:0] qp;
    logic [1:0][38:0] rr;
    logic [1:0][30:0] t_nx;

    if (i == 0) begin : g_first
      assign c_in = s2_c;
      assign v_in = s2_vld;
      assign t_in = {2{Q30_ONE}};
    end else begin : g_next
      assign c_in = it_c[i-1];
      assign v_in = it_v[i-1];
      assign t_in = it_t[i-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        yp[l] = 63'(c_in.x2[l]) * 63'(t_in[l]);
        qp[l] = 68'(a_y[i][l]) * 68'(SIN_RECIP[i]);
        rr[l] = 39'(b_y[i][l]) - 39'(b_q[i][l]) * 39'(SIN_DIV[i]);
        // reciprocal estimate is at most one short
        if (rr[l] >= 39'(SIN_DIV[i])) begin
          t_nx[l] = Q30_ONE - 31'(b_q[i][l] + 32'd1);
        end else begin
          t_nx[l] = Q30_ONE - 31'(b_q[i][l]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[i]  <= 1'b0;
        b_v[i]  <= 1'b0;
        it_v[i] <= 1'b0;
      end else if (en) begin
        a_v[i]  <= v_in;
        b_v[i]  <= a_v[i];
        it_v[i] <= b_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_c[i]  <= c_in;
        b_c[i]  <= a_c[i];
        it_c[i] <= b_c[i];
        b_y[i]  <= a_y[i];
        it_t[i] <= t_nx;
        for (int l = 0; l < 2; l++) begin
          a_y[i][l] <= yp[l][61:30];
          b_q[i][l] <= qp[l][67:36];
        end
      end
    end
  end

  // final: x * t, clamp to one, round to Q1.16
  logic             f1_vld, f2_vld;
  logic [1:0][31:0] f1_t;
  logic [TAG_W-1:0] f1_tag, f2_tag;
  logic [1:0][61:0] fp;
  logic [1:0][31:0] fcl;
  logic [1:0][16:0] f2_s;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fp[l]  = 62'(it_c[SIN_ITERS-1].x[l]) * 62'(it_t[SIN_ITERS-1][l]);
      fcl[l] = (f1_t[l] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : f1_t[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= it_v[SIN_ITERS-1];
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tag <= it_c[SIN_ITERS-1].tag;
      f2_tag <= f1_tag;
      for (int l = 0; l < 2; l++) begin
        f1_t[l] <= fp[l][61:30];
        f2_s[l] <= 17'((fcl[l] + 32'd8192) >> 14);
      end
    end
  end

  assign out_vld = f2_vld;
  assign sin_a   = f2_s[0];
  assign sin_b   = f2_s[1];
  assign out_tag = f2_tag;

endmodule

>>> hdl/fscm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module fscm_div #(
  parameter int DW    = fscm_pkg::DIV_DW,
  parameter int VW    = fscm_pkg::DIV_VW,
  parameter int QW    = fscm_pkg::DIV_QW,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DW-1:0]    dividend,
  input  logic [VW-1:0]    divisor,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [QW-1:0]    quotient,
  output logic             ovf,
  output logic [TAG_W-1:0] out_tag
);
  localparam int RW = VW + QW + 1;

  // entry stage: overflow when the quotient would not fit in QW bits
  logic             e_vld, e_ovf;
  logic [RW-1:0]    e_rem;
  logic [VW-1:0]    e_den;
  logic [TAG_W-1:0] e_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ovf <= RW'(dividend) >= (RW'(divisor) << QW);
      e_rem <= RW'(dividend);
      e_den <= divisor;
      e_tag <= in_tag;
    end
  end

  logic             vld_q [QW];
  logic             ovf_q [QW];
  logic [RW-1:0]    rem_q [QW];
  logic [VW-1:0]    den_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic [TAG_W-1:0] tag_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic             v_in, o_in;
    logic [RW-1:0]    rm_in, sh, rm_nx;
    logic [VW-1:0]    dn_in;
    logic [QW-1:0]    q_in, q_nx;
    logic [TAG_W-1:0] tg_in;

    if (j == 0) begin : g_src
      assign v_in  = e_vld;
      assign o_in  = e_ovf;
      assign rm_in = e_rem;
      assign dn_in = e_den;
      assign q_in  = '0;
      assign tg_in = e_tag;
    end else begin : g_chain
      assign v_in  = vld_q[j-1];
      assign o_in  = ovf_q[j-1];
      assign rm_in = rem_q[j-1];
      assign dn_in = den_q[j-1];
      assign q_in  = quo_q[j-1];
      assign tg_in = tag_q[j-1];
    end

    assign sh = RW'(dn_in) << (QW - 1 - j);

    always_comb begin
      rm_nx = rm_in;
      q_nx  = q_in;
      if (rm_in >= sh) begin
        rm_nx = rm_in - sh;
        q_nx[QW-1-j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[j] <= o_in;
        rem_q[j] <= rm_nx;
        den_q[j] <= dn_in;
        quo_q[j] <= q_nx;
        tag_q[j] <= tg_in;
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign quotient = quo_q[QW-1];
  assign ovf      = ovf_q[QW-1];
  assign out_tag  = tag_q[QW-1];

endmodule

>>> hdl/flux_surface_coordinate_map.sv
// Solov'ev flux surface map: (psi, angle) to normalized radial offset and height.
// Fully pipelined: one item is accepted every cycle unless the pipeline stalls.
// Its stages: psi root, sine pair, shaping math, two 64-bit roots, two dividers
// and the output register. The two wide square roots and the dividers, one bit
// per stage, set the latency. When the result register is held by the downstream
// side the whole pipeline stalls, and s_axis_tready drops.
// Registers (APB, 4-byte spacing): 0x0 inverse aspect Q0.16, 0x4 elongation
// Q4.12, 0x8 triangularity signed Q2.14; write them only while the pipe is empty.
module flux_surface_coordinate_map #(
  parameter int ANGLE_BITS = fscm_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] flux, [31:16] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] radial_offset, [38:18] height, [39] zero
  output logic [0:0]  m_axis_tuser,   // [0] invalid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fscm_pkg::*;

  localparam int ANG_MB = (ANGLE_BITS >= 16) ? 16 : ANGLE_BITS;
  localparam logic [15:0] ANG_MASK = 16'((32'd1 << ANG_MB) - 32'd1);

  typedef struct packed {
    logic [35:0]        p;
    logic signed [36:0] numr;
    logic signed [51:0] knum;
    logic               inv;
  } sqa_tag_t;

  typedef struct packed {
    logic [31:0]        root_a;
    logic signed [36:0] numr;
    logic signed [51:0] knum;
    logic               inv;
  } sqp_tag_t;

  typedef struct packed {
    logic [50:0] dvd_z;
    logic [31:0] den_z;
    logic        neg_r;
    logic        neg_z;
    logic        inv;
  } dvr_tag_t;

  typedef struct packed {
    logic [20:0] q_r;
    logic        ovf_r;
    logic        neg_r;
    logic        neg_z;
    logic        inv;
  } dvz_tag_t;

  // ---------------- configuration ----------------
  logic [15:0] aspect, elong, triang;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      aspect <= ASPECT_RST;
      elong  <= ELONG_RST;
      triang <= TRIANG_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ASPECT: aspect <= pwdata[15:0];
        REG_ELONG:  elong  <= pwdata[15:0];
        REG_TRIANG: triang <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ASPECT: prdata = {16'd0, aspect};
      REG_ELONG:  prdata = {16'd0, elong};
      REG_TRIANG: prdata = {16'd0, triang};
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- psi root, phase carried as tag ----------------
  logic [31:0] phase;
  logic        ps_vld;
  logic [15:0] ps_root;
  logic [31:0] ps_phase;

  assign phase = 32'(s_axis_tdata[31:16] & ANG_MASK) << (32 - ANGLE_BITS);

  fscm_sqrt #(.W(PSI_ROOT_W), .TAG_W(32)) u_psi_root (
    .clk, .rst, .en(adv),
    .in_vld  (s_axis_tvalid),
    .in_val  ({s_axis_tdata[15:0], 16'd0}),
    .in_tag  (phase),
    .out_vld (ps_vld),
    .out_root(ps_root),
    .out_tag (ps_phase)
  );

  // ---------------- sine and cosine ----------------
  logic        sn_vld;
  logic [16:0] sa, sb;
  logic [17:0] sn_tag;
  logic [15:0] s_w;
  logic [1:0]  quad;

  fscm_sine #(.TAG_W(18)) u_sine (
    .clk, .rst, .en(adv),
    .in_vld (ps_vld),
    .frac   (ps_phase[29:0]),
    .in_tag ({ps_root, ps_phase[31:30]}),
    .out_vld(sn_vld),
    .sin_a  (sa),
    .sin_b  (sb),
    .out_tag(sn_tag)
  );

  assign s_w  = sn_tag[17:2];
  assign quad = sn_tag[1:0];

  logic signed [17:0] sa_s, sb_s, sn_c, cs_c;
  assign sa_s = $signed({1'b0, sa});
  assign sb_s = $signed({1'b0, sb});

  always_comb begin
    case (quad)
      2'd0:    begin sn_c = sa_s;  cs_c = sb_s;  end
      2'd1:    begin sn_c = sb_s;  cs_c = -sa_s; end
      2'd2:    begin sn_c = -sa_s; cs_c = -sb_s; end
      default: begin sn_c = -sb_s; cs_c = sa_s;  end
    endcase
  end

  logic signed [16:0] e_s, k_s;
  logic signed [15:0] d_s;
  assign e_s = $signed({1'b0, aspect});
  assign k_s = $signed({1'b0, elong});
  assign d_s = $signed(triang);

  // ---------------- shaping math ----------------
  // B1: s*cos, s*sin, e^2
  logic               b1_vld;
  logic signed [34:0] b1_sc, b1_ssn;
  logic [31:0]        b1_ee;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else if (adv) begin
      b1_vld <= sn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sc  <= $signed({19'd0, s_w}) * 35'(cs_c);
      b1_ssn <= $signed({19'd0, s_w}) * 35'(sn_c);
      b1_ee  <= 32'(aspect) * 32'(aspect);
    end
  end

  // B2: e*s*cos, k*s*sin, radial numerator
  logic               b2_vld;
  logic signed [51:0] b2_escr, b2_knum;
  logic signed [36:0] b2_numr;
  logic [31:0]        b2_ee;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_vld <= 1'b0;
    end else if (adv) begin
      b2_vld <= b1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_escr <= 52'(e_s) * 52'(b1_sc);
      b2_knum <= 52'(k_s) * 52'(b1_ssn);
      b2_numr <= (37'(b1_sc) <<< 1) + $signed({5'd0, aspect, 16'd0});
      b2_ee   <= b1_ee;
    end
  end

  // B3: esc rounded, radial root argument
  logic               b3_vld;
  logic signed [36:0] b3_esc;
  logic signed [40:0] b3_argr;
  logic [31:0]        b3_ee;
  logic signed [36:0] b3_numr;
  logic signed [51:0] b3_knum;
  logic signed [36:0] esc_c;

  assign esc_c = 37'(rnd_shr(64'(b2_escr), 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_vld <= 1'b0;
    end else if (adv) begin
      b3_vld <= b2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_esc  <= esc_c;
      b3_argr <= 41'(64'sd4294967296 + (64'(esc_c) <<< 1) + $signed(64'(b2_ee)));
      b3_ee   <= b2_ee;
      b3_numr <= b2_numr;
      b3_knum <= b2_knum;
    end
  end

  // B4: triangularity products
  logic               b4_vld;
  logic signed [52:0] b4_t1;
  logic signed [48:0] b4_t2;
  logic signed [40:0] b4_argr;
  logic [31:0]        b4_ee;
  logic signed [36:0] b4_numr;
  logic signed [51:0] b4_knum;

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_vld <= 1'b0;
    end else if (adv) begin
      b4_vld <= b3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_t1   <= (53'(b3_esc) * 53'(d_s)) <<< 1;
      b4_t2   <= $signed({17'd0, b3_ee}) * 49'(d_s);
      b4_argr <= b3_argr;
      b4_ee   <= b3_ee;
      b4_numr <= b3_numr;
      b4_knum <= b3_knum;
    end
  end

  // B5: height factor N and M = 1 - e^2/4
  logic               b5_vld;
  logic signed [39:0] b5_nd;
  logic [30:0]        b5_m30;
  logic signed [40:0] b5_argr;
  logic signed [36:0] b5_numr;
  logic signed [51:0] b5_knum;

  always_ff @(posedge clk) begin
    if (rst) begin
      b5_vld <= 1'b0;
    end else if (adv) begin
      b5_vld <= b4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_nd   <= 40'(64'sd4294967296 + rnd_shr(64'(b4_t1), 14) + rnd_shr(64'(b4_t2), 14));
      b5_m30  <= 31'((64'h4_0000_0008 - 64'(b4_ee)) >> 4);
      b5_argr <= b4_argr;
      b5_numr <= b4_numr;
      b5_knum <= b4_knum;
    end
  end

  // B6: M * N
  logic               b6_vld, b6_ndpos;
  logic [63:0]        b6_mn;
  logic signed [40:0] b6_argr;
  logic signed [36:0] b6_numr;
  logic signed [51:0] b6_knum;
  logic [33:0]        n30_c;

  assign n30_c = 34'((64'(b5_nd) + 64'd2) >> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      b6_vld <= 1'b0;
    end else if (adv) begin
      b6_vld <= b5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b6_ndpos <= b5_nd > 40'sd0;
      b6_mn    <= 64'(b5_m30) * 64'(n30_c);
      b6_argr  <= b5_argr;
      b6_numr  <= b5_numr;
      b6_knum  <= b5_knum;
    end
  end

  // B7: P rounded, invalid decision
  logic        b7_vld;
  sqa_tag_t    b7_tag;
  logic [34:0] b7_argr;
  logic [35:0] p_c;

  assign p_c = 36'((b6_mn + 64'h800_0000) >> 28);

  always_ff @(posedge clk) begin
    if (rst) begin
      b7_vld <= 1'b0;
    end else if (adv) begin
      b7_vld <= b6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b7_argr     <= b6_argr[34:0];
      b7_tag.p    <= p_c;
      b7_tag.numr <= b6_numr;
      b7_tag.knum <= b6_knum;
      b7_tag.inv  <= (b6_argr <= 41'sd0) || !b6_ndpos || (p_c == '0);
    end
  end

  // ---------------- wide roots ----------------
  logic        sqa_vld;
  logic [31:0] root_a;
  sqa_tag_t    sqa_tag;

  fscm_sqrt #(.W(WIDE_ROOT_W), .TAG_W($bits(sqa_tag_t))) u_root_a (
    .clk, .rst, .en(adv),
    .in_vld  (b7_vld),
    .in_val  (64'(b7_argr) << 28),
    .in_tag  (b7_tag),
    .out_vld (sqa_vld),
    .out_root(root_a),
    .out_tag (sqa_tag)
  );

  logic        sqp_vld;
  logic [31:0] root_p;
  sqp_tag_t    sqp_in, sqp_tag;

  assign sqp_in.root_a = root_a;
  assign sqp_in.numr   = sqa_tag.numr;
  assign sqp_in.knum   = sqa_tag.knum;
  assign sqp_in.inv    = sqa_tag.inv;

  fscm_sqrt #(.W(WIDE_ROOT_W), .TAG_W($bits(sqp_tag_t))) u_root_p (
    .clk, .rst, .en(adv),
    .in_vld  (sqa_vld),
    .in_val  (64'(sqa_tag.p[34:0]) << 28),
    .in_tag  (sqp_in),
    .out_vld (sqp_vld),
    .out_root(root_p),
    .out_tag (sqp_tag)
  );

  // ---------------- divisions ----------------
  logic [36:0] mag_r;
  logic [51:0] mag_z;
  logic [32:0] den_r;
  logic [50:0] dvd_r;
  dvr_tag_t    dvr_in, dvr_tag;

  assign mag_r = sqp_tag.numr[36] ? 37'(-sqp_tag.numr) : 37'(sqp_tag.numr);
  assign mag_z = sqp_tag.knum[51] ? 52'(-sqp_tag.knum) : 52'(sqp_tag.knum);
  assign den_r = 33'(Q30_ONE) + 33'(sqp_tag.root_a);
  assign dvd_r = 51'((64'(mag_r) << 14) + 64'(den_r >> 1));

  assign dvr_in.dvd_z = 51'((64'(mag_z) << 2) + 64'(root_p >> 1));
  assign dvr_in.den_z = root_p;
  assign dvr_in.neg_r = sqp_tag.numr[36];
  assign dvr_in.neg_z = sqp_tag.knum[51];
  assign dvr_in.inv   = sqp_tag.inv;

  logic        dvr_vld, ovf_r;
  logic [20:0] q_r;

  fscm_div #(.DW(DIV_DW), .VW(DIV_VW), .QW(DIV_QW), .TAG_W($bits(dvr_tag_t))) u_div_r (
    .clk, .rst, .en(adv),
    .in_vld  (sqp_vld),
    .dividend(dvd_r),
    .divisor (den_r),
    .in_tag  (dvr_in),
    .out_vld (dvr_vld),
    .quotient(q_r),
    .ovf     (ovf_r),
    .out_tag (dvr_tag)
  );

  dvz_tag_t    dvz_in, dvz_tag;
  logic        dvz_vld, ovf_z;
  logic [20:0] q_z;

  assign dvz_in.q_r   = q_r;
  assign dvz_in.ovf_r = ovf_r;
  assign dvz_in.neg_r = dvr_tag.neg_r;
  assign dvz_in.neg_z = dvr_tag.neg_z;
  assign dvz_in.inv   = dvr_tag.inv;

  fscm_div #(.DW(DIV_DW), .VW(DIV_VW), .QW(DIV_QW), .TAG_W($bits(dvz_tag_t))) u_div_z (
    .clk, .rst, .en(adv),
    .in_vld  (dvr_vld),
    .dividend(dvr_tag.dvd_z),
    .divisor (33'(dvr_tag.den_z)),
    .in_tag  (dvz_in),
    .out_vld (dvz_vld),
    .quotient(q_z),
    .ovf     (ovf_z),
    .out_tag (dvz_tag)
  );

  // ---------------- sign, saturation, output register ----------------
  logic signed [17:0] r_c;
  logic signed [20:0] z_c;

  always_comb begin
    if (dvz_tag.inv) begin
      r_c = '0;
    end else if (!dvz_tag.neg_r) begin
      r_c = (dvz_tag.ovf_r || dvz_tag.q_r > 21'd131071) ? 18'sd131071 : 18'(dvz_tag.q_r);
    end else begin
      r_c = (dvz_tag.ovf_r || dvz_tag.q_r > 21'd131072) ? -18'sd131072
                                                        : 18'(-$signed({1'b0, dvz_tag.q_r}));
    end
    if (dvz_tag.inv) begin
      z_c = '0;
    end else if (!dvz_tag.neg_z) begin
      z_c = (ovf_z || q_z > 21'd1048575) ? 21'sd1048575 : $signed(q_z);
    end else begin
      z_c = (ovf_z || q_z > 21'd1048576) ? -21'sd1048576 : 21'(-$signed({1'b0, q_z}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dvz_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {1'b0, z_c, r_c};
      m_axis_tuser <= dvz_tag.inv;
    end
  end

  // ---------------- checks ----------------
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero data");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

>>> bench/flux_surface_coordinate_map_check.sv
// Checker for the flux surface map: predicts each result from the accepted items and compares.
module flux_surface_coordinate_map_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          errors
);
  import fscm_pkg::*;

  typedef struct packed {
    logic [17:0] radial;
    logic [20:0] height;
    logic        invalid;
  } point_t;

  point_t           want_q[$];
  logic [15:0]      aspect, elong, triang;
  longint unsigned  half_pi = 64'd1686629713;
  longint unsigned  one30 = 64'd1 << 30;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned acc, b;
    acc = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= acc + b) begin
        v -= acc + b;
        acc = (acc >> 1) + b;
      end else begin
        acc >>= 1;
      end
      b >>= 2;
    end
    return acc;
  endfunction

  // divide rounded to nearest, ties away from zero; den positive
  function automatic longint div_round(longint num, longint den);
    longint unsigned mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + (den >> 1)) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  // sine of a quarter-turn fraction (Q0.30) as Q1.16
  function automatic longint quarter_sine(longint unsigned fr);
    longint unsigned x, x2, t;
    longint unsigned dv[5];
    dv = '{110, 72, 42, 20, 6};
    x = (fr * half_pi) >> 30;
    x2 = (x * x) >> 30;
    t = one30;
    for (int i = 0; i < 5; i++) t = one30 - ((x2 * t) >> 30) / dv[i];
    t = (x * t) >> 30;
    if (t > one30) t = one30;
    return longint'((t + 8192) >> 14);
  endfunction

  function automatic point_t map_point(logic [15:0] psi, logic [15:0] ang);
    point_t o;
    longint unsigned ph, fr;
    longint sa, sb, sn, cs, s, e, k, d, ee, esc, ar, nd, m30, n30, p, r, z;
    ph = longint'(ang) << 16;
    fr = ph & (one30 - 1);
    sa = quarter_sine(fr);
    sb = quarter_sine(one30 - fr);
    case (ph[31:30])
      2'd0: begin sn = sa; cs = sb; end
      2'd1: begin sn = sb; cs = -sa; end
      2'd2: begin sn = -sa; cs = -sb; end
      default: begin sn = -sb; cs = sa; end
    endcase
    s = longint'(root_floor(longint'(psi) << 16));
    e = aspect;
    k = elong;
    d = longint'($signed(triang));
    ee = e * e;
    esc = div_round(e * s * cs, 64'sd1 << 16);
    ar = (64'sd1 << 32) + 2 * esc + ee;
    nd = (64'sd1 << 32) + div_round(2 * esc * d, 64'sd1 << 14) + div_round(ee * d, 64'sd1 << 14);
    m30 = longint'(((64'd1 << 34) - ee + 8) >> 4);
    p = 0;
    if (nd > 0) begin
      n30 = div_round(nd, 4);
      p = div_round(m30 * n30, 64'sd1 << 28);
    end
    o = '0;
    if (ar <= 0 || nd <= 0 || p <= 0) begin
      o.invalid = 1'b1;
      return o;
    end
    r = div_round((2 * s * cs + e * 65536) * 16384,
                  longint'(one30) + longint'(root_floor(longint'(ar) << 28)));
    r = r < -131072 ? -131072 : (r > 131071 ? 131071 : r);
    z = div_round(k * s * sn * 4, longint'(root_floor(longint'(p) << 28)));
    z = z < -1048576 ? -1048576 : (z > 1048575 ? 1048575 : z);
    o.radial = r[17:0];
    o.height = z[20:0];
    return o;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    point_t got, want;
    if (rst) begin
      aspect <= ASPECT_RST;
      elong  <= ELONG_RST;
      triang <= TRIANG_RST;
      errors <= 0;
      want_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ASPECT: aspect <= pwdata[15:0];
          REG_ELONG:  elong  <= pwdata[15:0];
          REG_TRIANG: triang <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        want_q.push_back(map_point(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[17:0], m_axis_tdata[38:18], m_axis_tuser[0]};
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want || m_axis_tdata[39] !== 1'b0) begin
            $display("%0t: mismatch radial exp %h got %h, height exp %h got %h, invalid exp %b got %b",
                     $time, want.radial, got.radial, want.height, got.height,
                     want.invalid, got.invalid);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/flux_surface_coordinate_map_test.sv
// Testbench top for the flux surface map: stimulus, register phases and verdict.
module flux_surface_coordinate_map_test;
  import fscm_pkg::*;

  logic        clk = 0, rst = 1;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int          pending, errors;
  bit          calm;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  flux_surface_coordinate_map dut (.*);
  flux_surface_coordinate_map_check check (.*);

  task automatic reg_write(logic [3:0] addr, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_shape(logic [15:0] e, logic [15:0] k, logic [15:0] d);
    while (pending != 0) @(posedge clk);
    reg_write(4'(4 * REG_ASPECT), {16'($urandom), e});
    reg_write(4'(4 * REG_ELONG), {16'($urandom), k});
    reg_write(4'(4 * REG_TRIANG), {16'($urandom), d});
  endtask

  task automatic send_point(logic [15:0] psi, logic [15:0] ang);
    while (!calm && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {ang, psi};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_point(16'hffff, 16'($urandom_range(3)) << 14);
        1: send_point(16'($urandom_range(15)), 16'($urandom));
        default: send_point(16'($urandom), 16'($urandom));
      endcase
    end
    s_axis_tvalid <= 0;
  endtask

  // downstream side: random stalls, one long hold-off, one calm stretch
  initial begin
    @(negedge rst);
    repeat (1500) begin
      m_axis_tready <= $urandom_range(99) >= 20;
      @(posedge clk);
    end
    repeat (600) begin
      m_axis_tready <= 0;
      @(posedge clk);
    end
    repeat (800) begin
      m_axis_tready <= 1;
      @(posedge clk);
    end
    forever begin
      m_axis_tready <= $urandom_range(99) >= 20;
      @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [15:0] angs[6];
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h0001};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset shape, corner points
    foreach (angs[i]) begin
      send_point(16'h0000, angs[i]);
      send_point(16'hffff, angs[i]);
    end
    s_axis_tvalid <= 0;
    // extreme shape: radial root argument and height factor go non-positive
    set_shape(16'hffff, 16'hffff, 16'h8000);
    reg_write(4'hc, $urandom);
    foreach (angs[i]) send_point(16'hffff, angs[i]);
    send_point(16'h8000, 16'h2000);
    s_axis_tvalid <= 0;
    set_shape(16'h0001, 16'h0001, 16'h7fff);
    send_random(150);
    set_shape(16'hffff, 16'hffff, 16'h7fff);
    send_random(150);
    calm = 1;
    set_shape(16'h0000, 16'h0000, 16'h8000);
    send_random(300);
    calm = 0;
    repeat (4) begin
      set_shape(16'($urandom), 16'($urandom), 16'($urandom));
      send_random(225);
    end
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

>>> files.f
hdl/fscm_pkg.sv
hdl/fscm_sqrt.sv
hdl/fscm_sine.sv
hdl/fscm_div.sv
hdl/flux_surface_coordinate_map.sv
bench/flux_surface_coordinate_map_check.sv
bench/flux_surface_coordinate_map_test.sv
